>>> sv/km2d_pkg.sv
// ----------------------------------------------------------------------------
// km2d_pkg
// Shared types and constants of the 2D k-means iteration unit.
// ----------------------------------------------------------------------------
package km2d_pkg;

    localparam int MaxMeans  = 16;
    localparam int MaxPoints = 1024;
    localparam int IdxW      = $clog2(MaxMeans);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int SumW      = 32 + CntW + 1;
    localparam int DistW     = 65;

    // configuration register indexes
    localparam logic [1:0] CfgStartX = 2'd0;
    localparam logic [1:0] CfgStartY = 2'd1;
    localparam logic [1:0] CfgStartZ = 2'd2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [4:0]         cluster_count;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic [3:0]         mean_index;
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic               last_mean;
    } t_mean;

    // divider control/status
    typedef struct packed {
        logic                   start;
        logic signed [SumW-1:0] dividend;
        logic [CntW-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quotient;
    } t_div_rsp;

endpackage

>>> sv/km2d_div.sv
// ----------------------------------------------------------------------------
// km2d_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module km2d_div
    import km2d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int StepW = $clog2(SumW + 1);

    logic [SumW-1:0]  r_quo, n_quo;
    logic [SumW:0]    r_rem, n_rem;
    logic [CntW-1:0]  r_den;
    logic             r_neg;
    logic [StepW-1:0] r_step;
    logic             r_busy, r_done;
    logic [SumW:0]    w_trial;
    logic [SumW-1:0]  w_mag, w_res;

    // magnitude of the dividend
    assign w_mag   = i_req.dividend[SumW-1] ? SumW'(-i_req.dividend) : i_req.dividend;
    assign w_trial = {r_rem[SumW-1:0], r_quo[SumW-1]};

    always_comb begin
        n_quo = {r_quo[SumW-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= (SumW+1)'(r_den)) begin
            n_rem    = w_trial - (SumW+1)'(r_den);
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= StepW'(SumW - 1);
                r_quo  <= w_mag;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_neg  <= i_req.dividend[SumW-1];
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign w_res          = r_neg ? SumW'(-r_quo) : r_quo;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = w_res[31:0];

endmodule

>>> sv/kmeans_2d_iteration_unit.sv
// ----------------------------------------------------------------------------
// kmeans_2d_iteration_unit
// One Lloyd k-means iteration over streamed points, clustering on x and z.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy low. Assignment compares
// the point with each active mean in turn on one shared squared-distance and
// compare unit, one mean per cycle. On a last point the unit then divides
// each cluster sum by its count on a shared bit-serial divider, one
// coordinate after another, and presents each new mean for exactly one cycle
// on o_mean_valid; results cannot be held off. Configuration writes set the
// start position used as mean 0 of the first set.
module kmeans_2d_iteration_unit
    import km2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_point      i_point,
    output logic        o_mean_valid,
    output t_mean       o_mean,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_DIST = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state;
    logic signed [31:0] r_start_x, r_start_y, r_start_z;
    logic signed [31:0] r_mx [MaxMeans], r_my [MaxMeans], r_mz [MaxMeans];
    logic signed [SumW-1:0] r_sx [MaxMeans], r_sy [MaxMeans], r_sz [MaxMeans];
    logic [CntW-1:0] r_cnt [MaxMeans];
    logic [IdxW:0] r_active;
    logic signed [31:0] r_fx, r_fy, r_fz;
    logic r_started, r_in_set;
    t_point r_pt;
    logic [IdxW-1:0] r_m, r_best;
    logic [DistW-1:0] r_bdist;
    logic [1:0] r_axis;
    logic signed [31:0] r_qx, r_qy;
    logic r_valid;
    t_mean r_out;
    logic [4:0] w_k;
    logic [IdxW:0] w_kc;
    logic signed [32:0] w_dx, w_dz;
    logic [32:0] w_ax, w_az;
    logic [63:0] w_sqx, w_sqz;
    logic [DistW-1:0] w_dist;
    logic w_last_m;
    t_div_req w_req;
    t_div_rsp w_rsp;

    // clamp of the requested count
    assign w_k  = i_point.cluster_count;
    assign w_kc = (w_k == 5'd0) ? (IdxW+1)'(1) :
                  (w_k > 5'(MaxMeans)) ? (IdxW+1)'(MaxMeans) : (IdxW+1)'(w_k);

    // shared squared-distance unit
    assign w_dx   = 33'(r_pt.pos_x) - 33'(r_mx[r_m]);
    assign w_dz   = 33'(r_pt.pos_z) - 33'(r_mz[r_m]);
    assign w_ax   = w_dx[32] ? 33'(-w_dx) : w_dx;
    assign w_az   = w_dz[32] ? 33'(-w_dz) : w_dz;
    assign w_sqx  = 64'(w_ax[31:0]) * 64'(w_ax[31:0]);
    assign w_sqz  = 64'(w_az[31:0]) * 64'(w_az[31:0]);
    assign w_dist = {1'b0, w_sqx} + {1'b0, w_sqz};
    assign w_last_m = ((IdxW+1)'(r_m) + 1'b1) == r_active;

    // divider request
    always_comb begin
        w_req.start    = (r_state == S_DIV);
        w_req.divisor  = r_cnt[r_m];
        w_req.dividend = (r_axis == 2'd0) ? r_sx[r_m] :
                         (r_axis == 2'd1) ? r_sy[r_m] : r_sz[r_m];
    end

    km2d_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign busy = (r_state != S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgStartX: r_start_x <= i_cfg_data;
                CfgStartY: r_start_y <= i_cfg_data;
                CfgStartZ: r_start_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        logic signed [31:0] v_z;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= (IdxW+1)'(1);
            r_started <= 1'b0;
            r_in_set  <= 1'b0;
            r_valid   <= 1'b0;
            r_fx <= '0; r_fy <= '0; r_fz <= '0;
            for (int i = 0; i < MaxMeans; i++) begin
                r_sx[i] <= '0; r_sy[i] <= '0; r_sz[i] <= '0; r_cnt[i] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_pt <= i_point;
                    r_m  <= '0;
                    if (!r_in_set) begin
                        if (!r_started) begin
                            r_mx[0] <= r_start_x; r_my[0] <= r_start_y;
                            r_mz[0] <= r_start_z;
                            r_started <= 1'b1;
                        end
                        r_fx <= i_point.pos_x; r_fy <= i_point.pos_y;
                        r_fz <= i_point.pos_z;
                        for (int i = 0; i < MaxMeans; i++) begin
                            if ((IdxW+1)'(i) >= (r_started ? r_active : (IdxW+1)'(1))
                                && (IdxW+1)'(i) < w_kc) begin
                                r_mx[i] <= i_point.pos_x; r_my[i] <= i_point.pos_y;
                                r_mz[i] <= i_point.pos_z;
                            end
                        end
                        r_active <= w_kc;
                        r_in_set <= 1'b1;
                        r_state  <= S_INIT;
                    end else begin
                        r_state <= S_DIST;
                    end
                end
                S_INIT: r_state <= S_DIST;
                // one mean per cycle through the distance unit
                S_DIST: begin
                    if (r_m == '0 || w_dist < r_bdist) begin
                        r_bdist <= w_dist;
                        r_best  <= r_m;
                    end
                    if (w_last_m) r_state <= S_ACC;
                    else r_m <= r_m + 1'b1;
                end
                S_ACC: begin
                    if (r_cnt[r_best] < CntW'(MaxPoints)) begin
                        r_sx[r_best]  <= r_sx[r_best] + SumW'(r_pt.pos_x);
                        r_sy[r_best]  <= r_sy[r_best] + SumW'(r_pt.pos_y);
                        r_sz[r_best]  <= r_sz[r_best] + SumW'(r_pt.pos_z);
                        r_cnt[r_best] <= r_cnt[r_best] + 1'b1;
                    end
                    r_m    <= '0;
                    r_axis <= 2'd0;
                    r_state <= r_pt.last_point ? S_DIV : S_IDLE;
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: if (w_rsp.done) begin
                    v_z = (r_cnt[r_m] == '0) ? 32'sd0 : w_rsp.quotient;
                    if (r_axis == 2'd0) begin
                        r_qx <= v_z; r_axis <= 2'd1; r_state <= S_DIV;
                    end else if (r_axis == 2'd1) begin
                        r_qy <= v_z; r_axis <= 2'd2; r_state <= S_DIV;
                    end else begin
                        if (r_qx == 0 && r_qy == 0 && v_z == 0) begin
                            r_out.mean_x <= r_fx; r_out.mean_y <= r_fy;
                            r_out.mean_z <= r_fz;
                        end else begin
                            r_out.mean_x <= r_qx; r_out.mean_y <= r_qy;
                            r_out.mean_z <= v_z;
                        end
                        r_state <= S_EMIT;
                    end
                end
                // present one new mean and store it
                S_EMIT: begin
                    r_out.mean_index <= 4'(r_m);
                    r_out.last_mean  <= w_last_m;
                    r_valid <= 1'b1;
                    r_mx[r_m] <= r_out.mean_x; r_my[r_m] <= r_out.mean_y;
                    r_mz[r_m] <= r_out.mean_z;
                    r_axis <= 2'd0;
                    if (w_last_m) begin
                        for (int i = 0; i < MaxMeans; i++) begin
                            r_sx[i] <= '0; r_sy[i] <= '0; r_sz[i] <= '0; r_cnt[i] <= '0;
                        end
                        r_in_set <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_m <= r_m + 1'b1;
                        r_state <= S_DIV;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_mean_valid = r_valid;
    assign o_mean       = r_out;

    // checks
    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && start) |=> !(r_state == S_INIT)) else $error("start taken while busy");
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active >= 1) && (r_active <= (IdxW+1)'(MaxMeans))) else $error("active count");
    a_emit_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_in_set) else $error("emit outside set");

endmodule

>>> tb/kmeans_2d_iteration_unit_tb.sv
// ----------------------------------------------------------------------------
// kmeans_2d_iteration_unit_tb
// Self-checking bench for the streamed 2D k-means iteration unit.
// ----------------------------------------------------------------------------
// Points go in as start/busy command transfers and a behavioural model of the
// Lloyd update predicts every mean that comes out. A checker compares each
// strobed mean with the oldest prediction. Directed sets cover extremes, ties,
// empty and zero-mean clusters and out-of-range counts; random sets follow,
// with random gaps for all but the last points.
// ----------------------------------------------------------------------------
module kmeans_2d_iteration_unit_tb;
    import km2d_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_point      i_point;
    logic        o_mean_valid;
    t_mean       o_mean;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    kmeans_2d_iteration_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point      (i_point),
        .o_mean_valid (o_mean_valid),
        .o_mean       (o_mean),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // model state
    longint mdl_start_x, mdl_start_y, mdl_start_z;
    longint mdl_mx[MaxMeans], mdl_my[MaxMeans], mdl_mz[MaxMeans];
    longint mdl_sx[MaxMeans], mdl_sy[MaxMeans], mdl_sz[MaxMeans];
    int     mdl_cnt[MaxMeans];
    int     mdl_active;
    longint mdl_fx, mdl_fy, mdl_fz;
    bit     mdl_started, mdl_in_set;

    t_mean  pending_means[$];
    int     n_errors;
    int     n_points;
    int     n_sets;
    int     n_means_seen;
    bit     allow_gaps;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard limit
    initial begin
        #100000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic clear_sums();
        for (int m = 0; m < MaxMeans; m++) begin
            mdl_sx[m] = 0; mdl_sy[m] = 0; mdl_sz[m] = 0; mdl_cnt[m] = 0;
        end
    endtask

    // Lloyd update for one point; queues new means after a last point
    task automatic predict_means(input t_point p);
        longint      px, py, pz, nx, ny, nz;
        int          k, best;
        logic [63:0] dx, dz;
        logic [64:0] a, b, d, bd;
        t_mean       r;
        px = p.pos_x; py = p.pos_y; pz = p.pos_z;
        k  = p.cluster_count;
        bd = '0;
        best = 0;
        if (!mdl_in_set) begin
            if (!mdl_started) begin
                mdl_mx[0] = mdl_start_x; mdl_my[0] = mdl_start_y;
                mdl_mz[0] = mdl_start_z;
                mdl_active = 1;
                mdl_started = 1'b1;
            end
            if (k < 1) k = 1;
            if (k > MaxMeans) k = MaxMeans;
            mdl_fx = px; mdl_fy = py; mdl_fz = pz;
            for (int m = mdl_active; m < k; m++) begin
                mdl_mx[m] = px; mdl_my[m] = py; mdl_mz[m] = pz;
            end
            mdl_active = k;
            clear_sums();
            mdl_in_set = 1'b1;
        end
        // nearest mean, lower index wins a tie
        for (int m = 0; m < mdl_active; m++) begin
            dx = (px >= mdl_mx[m]) ? px - mdl_mx[m] : mdl_mx[m] - px;
            dz = (pz >= mdl_mz[m]) ? pz - mdl_mz[m] : mdl_mz[m] - pz;
            a = dx * dx;
            b = dz * dz;
            d = a + b;
            if (m == 0 || d < bd) begin
                bd = d; best = m;
            end
        end
        if (mdl_cnt[best] < MaxPoints) begin
            mdl_sx[best] += px; mdl_sy[best] += py; mdl_sz[best] += pz;
            mdl_cnt[best]++;
        end
        if (!p.last_point) return;
        for (int m = 0; m < mdl_active; m++) begin
            nx = 0; ny = 0; nz = 0;
            if (mdl_cnt[m] > 0) begin
                nx = mdl_sx[m] / mdl_cnt[m];
                ny = mdl_sy[m] / mdl_cnt[m];
                nz = mdl_sz[m] / mdl_cnt[m];
            end
            if (nx == 0 && ny == 0 && nz == 0) begin
                nx = mdl_fx; ny = mdl_fy; nz = mdl_fz;
            end
            mdl_mx[m] = nx; mdl_my[m] = ny; mdl_mz[m] = nz;
            r.mean_index = m[3:0];
            r.mean_x     = nx[31:0];
            r.mean_y     = ny[31:0];
            r.mean_z     = nz[31:0];
            r.last_mean  = (m + 1 == mdl_active);
            pending_means.insert(pending_means.size(), r);
        end
        clear_sums();
        mdl_in_set = 1'b0;
        n_sets++;
    endtask

    // result checker: every strobed mean against the oldest prediction
    always @(posedge i_clk) begin
        t_mean e;
        if (i_rst_n && o_mean_valid) begin
            n_means_seen++;
            if (pending_means.size() == 0) begin
                $error("unexpected mean: index %0d", o_mean.mean_index);
                n_errors++;
            end else begin
                e = pending_means.pop_front();
                if (o_mean.mean_index !== e.mean_index) begin
                    $error("mean_index: exp %0d got %0d", e.mean_index, o_mean.mean_index);
                    n_errors++;
                end
                if (o_mean.mean_x !== e.mean_x) begin
                    $error("mean_x: exp %0d got %0d", e.mean_x, o_mean.mean_x);
                    n_errors++;
                end
                if (o_mean.mean_y !== e.mean_y) begin
                    $error("mean_y: exp %0d got %0d", e.mean_y, o_mean.mean_y);
                    n_errors++;
                end
                if (o_mean.mean_z !== e.mean_z) begin
                    $error("mean_z: exp %0d got %0d", e.mean_z, o_mean.mean_z);
                    n_errors++;
                end
                if (o_mean.last_mean !== e.last_mean) begin
                    $error("last_mean: exp %0d got %0d", e.last_mean, o_mean.last_mean);
                    n_errors++;
                end
            end
        end
    end

    // one point transfer; start stays high for a following point
    task automatic send_point(input t_point p);
        start   <= 1'b1;
        i_point <= p;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
        predict_means(p);
        n_points++;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic t_point make_point(longint x, longint y, longint z, int k, bit last);
        t_point p;
        p.pos_x = x[31:0]; p.pos_y = y[31:0]; p.pos_z = z[31:0];
        p.cluster_count = k[4:0];
        p.last_point = last;
        return p;
    endfunction

    // wait for outstanding means, then let the unit settle
    task automatic drain();
        start <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CfgStartX: mdl_start_x = longint'(signed'(data));
            CfgStartY: mdl_start_y = longint'(signed'(data));
            CfgStartZ: mdl_start_z = longint'(signed'(data));
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic longint rand_coord();
        case ($urandom_range(0, 4))
            0: return longint'(signed'($urandom));
            1: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            default: return longint'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    // start position: several settings, extremes last
    task automatic test_start_position();
        cfg_write(CfgStartX, 32'h1234_5678);
        cfg_write(CfgStartY, 32'hFFFF_0000);
        cfg_write(CfgStartZ, 32'h7FFF_FFFF);
        cfg_write(CfgStartX, 32'h8000_0000);
        cfg_write(CfgStartY, 32'h7FFF_FFFF);
        cfg_write(CfgStartZ, 32'h8000_0000);
        // first set: start mean plus two added means, far-apart extremes
        send_point(make_point(100, 5, -100, 3, 1'b0));
        send_point(make_point(-2147483648, -2147483648, -2147483648, 0, 1'b0));
        send_point(make_point(2147483647, 2147483647, 2147483647, 0, 1'b0));
        send_point(make_point(100, 0, -100, 31, 1'b1));
        drain();
        // start registers are only read once; these writes must change nothing
        cfg_write(CfgStartX, 32'h0000_0000);
        cfg_write(CfgStartY, 32'h0000_0100);
        cfg_write(CfgStartZ, 32'hFFFF_FF00);
    endtask

    task automatic test_directed();
        // count 0 acts as one mean, single point set
        send_point(make_point(7, 8, 9, 0, 1'b1));
        // full count, single point: empty clusters take the first point
        send_point(make_point(-300, 44, 300, 16, 1'b1));
        // count above the maximum
        send_point(make_point(10, 1, 0, 20, 1'b0));
        send_point(make_point(-10, -1, 0, 0, 1'b1));
        drain();
        // two means, symmetric points giving a zero mean
        send_point(make_point(0, 0, 0, 2, 1'b0));
        send_point(make_point(5, 3, 5, 2, 1'b0));
        send_point(make_point(-5, -3, -5, 2, 1'b0));
        send_point(make_point(1000, 0, 0, 2, 1'b1));
        drain();
        // equidistant point tests the tie rule
        send_point(make_point(0, 1, 0, 2, 1'b0));
        send_point(make_point(500, 2, 0, 2, 1'b1));
        // mixed signs, truncation toward zero
        send_point(make_point(-7, -7, -7, 1, 1'b0));
        send_point(make_point(-8, 4, 3, 1, 1'b1));
        drain();
    endtask

    task automatic test_random();
        int len, k, sent;
        sent = 0;
        while (sent < 380) begin
            allow_gaps = (sent < 310);
            len = $urandom_range(1, 12);
            k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                send_point(make_point(rand_coord(), rand_coord(), rand_coord(),
                                      i == 0 ? k : $urandom_range(0, 31), i == len - 1));
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        start = 1'b0; i_point = '0; i_cfg_we = 1'b0; i_cfg_index = CfgStartX;
        i_cfg_data = '0; i_rst_n = 1'b0;
        n_errors = 0; n_points = 0; n_sets = 0; n_means_seen = 0; allow_gaps = 1'b1;
        mdl_start_x = 0; mdl_start_y = 0; mdl_start_z = 0;
        for (int m = 0; m < MaxMeans; m++) begin
            mdl_mx[m] = 0; mdl_my[m] = 0; mdl_mz[m] = 0;
        end
        clear_sums();
        mdl_active = 1; mdl_fx = 0; mdl_fy = 0; mdl_fz = 0;
        mdl_started = 1'b0; mdl_in_set = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_position();
        test_directed();
        test_random();
        repeat (200) @(posedge i_clk);

        $display("Run covered %0d points in %0d sets, %0d means checked.",
                 n_points, n_sets, n_means_seen);
        if (n_errors == 0 && pending_means.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
